>>> sv/gps_lnav_subframe_decoder_macros.svh
// Assertion macros shared by the GPS LNAV subframe decoder RTL.
`ifndef GPS_LNAV_SUBFRAME_DECODER_MACROS_SVH
`define GPS_LNAV_SUBFRAME_DECODER_MACROS_SVH

// Same-cycle implication, sampled on aclk, off while reset is asserted.
`define GLN_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while reset is asserted.
`define GLN_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/gln_pkg.sv
// Types, constants and the parity function of the GPS LNAV subframe decoder.
package gln_pkg;

    localparam int NAV_WORD_W  = 32;
    localparam int VALUE_W     = 33;
    localparam int WEEK_OFS_W  = 12;
    localparam int OUT_TDATA_W = 56;
    localparam int MAX_RESULTS = 3;
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    localparam logic [WEEK_OFS_W-1:0] WEEK_OFFSET_RESET = 12'd1024;

    // Register index of week_offset in the configuration space.
    localparam logic REG_WEEK_OFFSET = 1'b0;

    // D30* of the previous word set means d1..d24 arrive inverted.
    localparam logic [NAV_WORD_W-1:0] DATA_INVERT_MASK = 32'h3FFF_FFC0;

    // Data bits d1..d24 taking part in each parity equation; d1 is bit 23.
    localparam logic [23:0] PAR_MASK [6] = '{
        24'hEC7CD2, 24'h763E69, 24'hBB1F34, 24'h5D8F9A, 24'hAEC7CD, 24'h2DEA27
    };
    // Bit i set: equation i uses D29* of the previous word, else D30*.
    localparam logic [5:0] PAR_USE_D29 = 6'b100101;

    typedef enum logic [4:0] {
        FC_NONE        = 5'd0,
        FC_SUBFRAME_ID = 5'd1,
        FC_TOW         = 5'd2,
        FC_WEEK        = 5'd3,
        FC_URA         = 5'd4,
        FC_HEALTH      = 5'd5,
        FC_IODC        = 5'd6,
        FC_TGD         = 5'd7,
        FC_TOC         = 5'd8,
        FC_AF2         = 5'd9,
        FC_AF1         = 5'd10,
        FC_AF0         = 5'd11,
        FC_IODE2       = 5'd12,
        FC_CRS         = 5'd13,
        FC_DELTA_N     = 5'd14,
        FC_M0          = 5'd15,
        FC_CUC         = 5'd16,
        FC_ECC         = 5'd17,
        FC_CUS         = 5'd18,
        FC_SQRT_A      = 5'd19,
        FC_TOE         = 5'd20,
        FC_CIC         = 5'd21,
        FC_OMEGA0      = 5'd22,
        FC_CIS         = 5'd23,
        FC_I0          = 5'd24,
        FC_CRC         = 5'd25,
        FC_OMEGA       = 5'd26,
        FC_OMEGA_DOT   = 5'd27,
        FC_IODE3       = 5'd28,
        FC_IDOT        = 5'd29
    } field_code_t;

    typedef struct packed {
        field_code_t               code;
        logic signed [VALUE_W-1:0] value;
    } gln_result_t;

    // Everything the back end needs to emit the results of one word.
    typedef struct packed {
        gln_result_t [MAX_RESULTS-1:0] res;
        logic [1:0]                    count_m1;
        logic [2:0]                    subframe;
        logic [3:0]                    position;
        logic                          parity_ok;
        logic [2:0]                    ready;
    } gln_item_t;

    // Layout of m_tdata, most significant member first.
    typedef struct packed {
        logic [6:0]                pad;
        logic [2:0]                ready_mask;
        logic                      parity_ok;
        logic [3:0]                word_position;
        logic [2:0]                subframe_number;
        logic signed [VALUE_W-1:0] field_value;
        field_code_t               field_code;
    } gln_beat_t;

    // Six parity equations over a word whose data bits are already de-inverted.
    function automatic logic nav_parity_good(input logic [NAV_WORD_W-1:0] w);
        logic ok;
        logic p;
        ok = 1'b1;
        for (int i = 0; i < 6; i++) begin
            p = ^(w[29:6] & PAR_MASK[i]) ^ (PAR_USE_D29[i] ? w[31] : w[30]);
            if (p != w[5-i]) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

endpackage

>>> sv/gln_front.sv
// Front end: accepts navigation words, checks parity, tracks position and decodes fields.
module gln_front
    import gln_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [NAV_WORD_W-1:0] nav_word,
    input  logic                  first_word,
    input  logic [WEEK_OFS_W-1:0] week_offset,
    output logic                  item_valid,
    input  logic                  item_ready,
    output gln_item_t             item
);

    logic [3:0] word_count_reg, word_count_next;
    logic [2:0] subframe_reg, subframe_next;
    logic [7:0] carried_reg, carried_next;
    logic [1:0] iodc_hi_reg, iodc_hi_next;
    logic [2:0] ready_reg, ready_next;

    logic                  push;
    logic [NAV_WORD_W-1:0] w;
    logic [31:0]           joined;
    logic [19:0]           tow_x6;
    logic [12:0]           week_sum;

    assign in_ready   = item_ready;
    assign item_valid = in_valid;
    assign push       = in_valid & item_ready;

    assign w        = nav_word[30] ? (nav_word ^ DATA_INVERT_MASK) : nav_word;
    assign joined   = {carried_reg, w[29:6]};
    assign tow_x6   = 20'({w[29:13], 2'b00}) + 20'({w[29:13], 1'b0});
    assign week_sum = 13'(w[29:20]) + 13'(week_offset);

    always_comb begin
        word_count_next = word_count_reg;
        subframe_next   = subframe_reg;
        carried_next    = carried_reg;
        iodc_hi_next    = iodc_hi_reg;
        ready_next      = ready_reg;
        item            = '0;

        if (first_word) begin
            word_count_next = 4'd1;
            subframe_next   = 3'd0;
        end else if (word_count_reg >= 4'd1 && word_count_reg < 4'd11) begin
            word_count_next = word_count_reg + 4'd1;
        end

        if (word_count_next == 4'd2) begin
            subframe_next     = w[10:8];
            item.res[0].code  = FC_SUBFRAME_ID;
            item.res[0].value = VALUE_W'(w[10:8]);
            item.res[1].code  = FC_TOW;
            item.res[1].value = VALUE_W'(tow_x6);
            item.count_m1     = 2'd1;
        end else if (word_count_next >= 4'd3 && word_count_next <= 4'd10) begin
            case (subframe_reg)
                3'd1: begin
                    case (word_count_next)
                        4'd3: begin
                            item.res[0] = '{FC_WEEK, VALUE_W'(week_sum)};
                            item.res[1] = '{FC_URA, VALUE_W'(w[17:14])};
                            item.res[2] = '{FC_HEALTH, VALUE_W'(w[13:8])};
                            item.count_m1 = 2'd2;
                            iodc_hi_next = w[7:6];
                        end
                        4'd7: item.res[0] = '{FC_TGD, VALUE_W'($signed(w[13:6]))};
                        4'd8: begin
                            item.res[0] = '{FC_IODC, VALUE_W'({iodc_hi_reg, w[29:22]})};
                            item.res[1] = '{FC_TOC, VALUE_W'({w[21:6], 4'b0000})};
                            item.count_m1 = 2'd1;
                        end
                        4'd9: begin
                            item.res[0] = '{FC_AF2, VALUE_W'($signed(w[29:22]))};
                            item.res[1] = '{FC_AF1, VALUE_W'($signed(w[21:6]))};
                            item.count_m1 = 2'd1;
                        end
                        4'd10: begin
                            item.res[0] = '{FC_AF0, VALUE_W'($signed(w[29:8]))};
                            ready_next  = ready_reg | 3'b001;
                        end
                        default: ;
                    endcase
                end
                3'd2: begin
                    case (word_count_next)
                        4'd3: begin
                            item.res[0] = '{FC_IODE2, VALUE_W'(w[29:22])};
                            item.res[1] = '{FC_CRS, VALUE_W'($signed(w[21:6]))};
                            item.count_m1 = 2'd1;
                        end
                        4'd4: begin
                            item.res[0] = '{FC_DELTA_N, VALUE_W'($signed(w[29:14]))};
                            carried_next = w[13:6];
                        end
                        4'd5: item.res[0] = '{FC_M0, VALUE_W'($signed(joined))};
                        4'd6: begin
                            item.res[0] = '{FC_CUC, VALUE_W'($signed(w[29:14]))};
                            carried_next = w[13:6];
                        end
                        4'd7: item.res[0] = '{FC_ECC, VALUE_W'(joined)};
                        4'd8: begin
                            item.res[0] = '{FC_CUS, VALUE_W'($signed(w[29:14]))};
                            carried_next = w[13:6];
                        end
                        4'd9: item.res[0] = '{FC_SQRT_A, VALUE_W'(joined)};
                        4'd10: begin
                            item.res[0] = '{FC_TOE, VALUE_W'({w[29:14], 4'b0000})};
                            ready_next  = ready_reg | 3'b010;
                        end
                        default: ;
                    endcase
                end
                3'd3: begin
                    case (word_count_next)
                        4'd3: begin
                            item.res[0] = '{FC_CIC, VALUE_W'($signed(w[29:14]))};
                            carried_next = w[13:6];
                        end
                        4'd4: item.res[0] = '{FC_OMEGA0, VALUE_W'($signed(joined))};
                        4'd5: begin
                            item.res[0] = '{FC_CIS, VALUE_W'($signed(w[29:14]))};
                            carried_next = w[13:6];
                        end
                        4'd6: item.res[0] = '{FC_I0, VALUE_W'($signed(joined))};
                        4'd7: begin
                            item.res[0] = '{FC_CRC, VALUE_W'($signed(w[29:14]))};
                            carried_next = w[13:6];
                        end
                        4'd8: item.res[0] = '{FC_OMEGA, VALUE_W'($signed(joined))};
                        4'd9: item.res[0] = '{FC_OMEGA_DOT, VALUE_W'($signed(w[29:6]))};
                        4'd10: begin
                            item.res[0] = '{FC_IODE3, VALUE_W'(w[29:22])};
                            item.res[1] = '{FC_IDOT, VALUE_W'($signed(w[21:8]))};
                            item.count_m1 = 2'd1;
                            ready_next  = ready_reg | 3'b100;
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end

        item.subframe  = subframe_next;
        item.position  = word_count_next;
        item.parity_ok = nav_parity_good(w);
        item.ready     = ready_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_count_reg <= '0;
            subframe_reg   <= '0;
            carried_reg    <= '0;
            iodc_hi_reg    <= '0;
            ready_reg      <= '0;
        end else if (push) begin
            word_count_reg <= word_count_next;
            subframe_reg   <= subframe_next;
            carried_reg    <= carried_next;
            iodc_hi_reg    <= iodc_hi_next;
            ready_reg      <= ready_next;
        end
    end

endmodule

>>> sv/gln_queue.sv
// Small first-in first-out queue of decoded word items between front and back end.
module gln_queue
    import gln_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      wr_valid,
    output logic      wr_ready,
    input  gln_item_t wr_item,
    output logic      rd_valid,
    input  logic      rd_pop,
    output gln_item_t rd_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    gln_item_t        item_mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr;
    logic             do_rd;

    assign wr_ready = (count_reg != CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_item  = item_mem[rd_ptr_reg];
    assign do_wr    = wr_valid & wr_ready;
    assign do_rd    = rd_pop & rd_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_wr, do_rd})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            item_mem[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

>>> sv/gln_back.sv
// Back end: steps through the results of each queued word into the output register.
module gln_back
    import gln_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   head_valid,
    input  gln_item_t              head_item,
    output logic                   head_pop,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tlast
);

    logic        valid_reg, valid_next;
    gln_beat_t   beat_reg, beat_next;
    logic        last_reg, last_next;
    logic [1:0]  slot_reg, slot_next;
    logic        load;
    logic        slot_last;
    gln_result_t sel;

    assign load      = !valid_reg || m_tready;
    assign sel       = head_item.res[slot_reg];
    assign slot_last = (slot_reg == head_item.count_m1);
    assign head_pop  = load & head_valid & slot_last;

    always_comb begin
        valid_next = valid_reg;
        beat_next  = beat_reg;
        last_next  = last_reg;
        slot_next  = slot_reg;
        if (load) begin
            valid_next = head_valid;
            if (head_valid) begin
                beat_next.pad             = '0;
                beat_next.ready_mask      = head_item.ready;
                beat_next.parity_ok       = head_item.parity_ok;
                beat_next.word_position   = head_item.position;
                beat_next.subframe_number = head_item.subframe;
                beat_next.field_value     = sel.value;
                beat_next.field_code      = sel.code;
                last_next                 = slot_last;
                slot_next                 = slot_last ? 2'd0 : slot_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            slot_reg  <= '0;
        end else begin
            valid_reg <= valid_next;
            slot_reg  <= slot_next;
        end
    end

    always_ff @(posedge aclk) begin
        beat_reg <= beat_next;
        last_reg <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = beat_reg;
    assign m_tlast  = last_reg;

endmodule

>>> sv/gps_lnav_subframe_decoder.sv
// Top level of the GPS LNAV subframe decoder: configuration register, front, queue and back end.
//
// The decoder takes one 30-bit legacy navigation word per input transaction, with the
// previous word's D29* and D30* in the two top bits of s_tdata and the subframe start
// flag in s_tuser. The front end undoes the D30* inversion, checks the six parity bits,
// tracks the word position and decodes the handover word's subframe id and time of week
// and every clock or ephemeris field of subframes 1 to 3 that completes in this word, all
// in the cycle the word is accepted. Each word yields one to three result transactions (a
// word without a field gives a single result with field code none), the final one marked
// by m_tlast. A four-entry queue of decoded words sits between the front and back end, so
// s_tready stays high as long as that queue has room, independent of whether m_tready is
// stalling. The back end, a registered output stage, emits one result per cycle while
// m_tready is high, so a word holds the output until all its results are out: one for
// most words, three at most (word 3 of subframe 1). The first result of a word is queued
// on acceptance and then registered in the output stage. week_offset (reset 1024) sits at
// byte address 0 of the APB port and should only be written while the decoder is idle.
module gps_lnav_subframe_decoder
    import gln_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // Input words.
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [NAV_WORD_W-1:0]  s_tdata,  // [31:0] nav_word
    input  logic [0:0]             s_tuser,  // [0] first_word
    // Decoded results.
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [4:0] field_code, [37:5] field_value, [40:38] subframe_number,
    // [44:41] word_position, [45] parity_ok, [48:46] ready_mask, [55:49] zero
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tlast,
    // Configuration port.
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [2:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    `include "gps_lnav_subframe_decoder_macros.svh"

    logic [WEEK_OFS_W-1:0] week_offset_reg, week_offset_next;
    logic                  cfg_write;

    logic      item_valid;
    logic      item_ready;
    gln_item_t item;
    logic      head_valid;
    logic      head_pop;
    gln_item_t head_item;
    gln_beat_t out_beat;

    // The register file is a single 12-bit register; paddr[2] selects the register slot.
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    always_comb begin
        week_offset_next = week_offset_reg;
        if (cfg_write && paddr[2] == REG_WEEK_OFFSET) begin
            week_offset_next = pwdata[WEEK_OFS_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            week_offset_reg <= WEEK_OFFSET_RESET;
        end else begin
            week_offset_reg <= week_offset_next;
        end
    end

    assign prdata = (paddr[2] == REG_WEEK_OFFSET) ? 32'(week_offset_reg) : '0;

    gln_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .nav_word    (s_tdata),
        .first_word  (s_tuser[0]),
        .week_offset (week_offset_reg),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item)
    );

    gln_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (item_valid),
        .wr_ready (item_ready),
        .wr_item  (item),
        .rd_valid (head_valid),
        .rd_pop   (head_pop),
        .rd_item  (head_item)
    );

    gln_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_item  (head_item),
        .head_pop   (head_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

    assign out_beat = m_tdata;

    // A word without a decoded field yields exactly one result.
    `GLN_ASSERT_NOW(a_none_is_last, m_tvalid && out_beat.field_code == FC_NONE, m_tlast, "field code none on a result that is not the last of its word")

    // Fields only come from words 2 to 10 of a subframe.
    `GLN_ASSERT_NOW(a_field_position, m_tvalid && out_beat.field_code != FC_NONE, out_beat.word_position >= 4'd2 && out_beat.word_position <= 4'd10, "field decoded outside words 2 to 10")

    // Clock and ephemeris fields only come from subframes 1 to 3.
    `GLN_ASSERT_NOW(a_field_subframe, m_tvalid && out_beat.field_code >= FC_WEEK, out_beat.subframe_number >= 3'd1 && out_beat.subframe_number <= 3'd3, "ephemeris field outside subframes 1 to 3")

    // With a full queue and a stalled output nothing drains, so input stays blocked.
    `GLN_ASSERT_NEXT(a_full_holds, m_tvalid && !m_tready && !s_tready, !s_tready, "queue drained while the output was stalled")

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench of the GPS LNAV subframe decoder with a word-level predictor.
module testbench
    import gln_pkg::*;
();

    // Byte address of week_offset on the APB port.
    localparam logic [2:0] ADDR_WEEK_OFFSET = 3'(4 * REG_WEEK_OFFSET);
    // Length of the long receiver hold-off, in clock cycles.
    localparam int HOLD_CYCLES = 80;
    // Upper bound on the cycles spent waiting for the decoder to drain.
    localparam int DRAIN_LIMIT = 20000;
    // Share of generated navigation words whose parity is deliberately broken.
    localparam int BAD_PARITY_PCT = 8;

    typedef struct {
        logic [31:0] word;
        logic        first_word;
    } nav_item_t;

    typedef struct {
        field_code_t code;
        logic [32:0] value;
        logic [2:0]  subframe;
        logic [3:0]  position;
        logic        parity_ok;
        logic [2:0]  ready;
        logic        last;
    } field_result_t;

    // Every input of the decoder starts at a known value.
    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [NAV_WORD_W-1:0]  s_tdata  = '0;
    logic [0:0]             s_tuser  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;
    logic                   psel     = 1'b0;
    logic                   penable  = 1'b0;
    logic                   pwrite   = 1'b0;
    logic [2:0]             paddr    = '0;
    logic [31:0]            pwdata   = '0;
    logic [31:0]            prdata;
    logic                   pready;

    gps_lnav_subframe_decoder u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // 20 ns clock period.
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Words waiting to be offered, and the decoded fields still owed by the decoder.
    nav_item_t     word_queue[$];
    field_result_t expected_fields[$];
    nav_item_t     next_word;

    int failures       = 0;
    int accepted_words = 0;
    int tx_idle_pct    = 14;
    int rx_idle_pct    = 62;
    logic rx_hold      = 1'b0;

    // Predictor state. It mirrors what the decoder keeps between words.
    logic [11:0] week_ofs   = WEEK_OFFSET_RESET;
    logic [3:0]  pos_count  = '0;
    logic [2:0]  sf_id      = '0;
    logic [7:0]  held_byte  = '0;
    logic [1:0]  iodc_top   = '0;
    logic [2:0]  done_mask  = '0;

    // Fields found in the word being predicted, before they get their common tags.
    field_code_t stage_code[3];
    logic [32:0] stage_val[3];
    int          stage_count;

    // Word generator state: the last two parity bits of the previously generated word.
    logic gen_d29 = 1'b0;
    logic gen_d30 = 1'b0;

    // The six LNAV parity equations over the true data bits; bit 5 of the result is D25.
    function automatic logic [5:0] parity_bits(logic d29s, logic d30s, logic [23:0] data);
        logic [24:1] d;
        logic [5:0]  p;
        for (int k = 1; k <= 24; k++) begin
            d[k] = data[24-k];
        end
        p[5] = d29s ^ d[1] ^ d[2] ^ d[3] ^ d[5] ^ d[6] ^ d[10] ^ d[11] ^ d[12] ^ d[13]
               ^ d[14] ^ d[17] ^ d[18] ^ d[20] ^ d[23];
        p[4] = d30s ^ d[2] ^ d[3] ^ d[4] ^ d[6] ^ d[7] ^ d[11] ^ d[12] ^ d[13] ^ d[14]
               ^ d[15] ^ d[18] ^ d[19] ^ d[21] ^ d[24];
        p[3] = d29s ^ d[1] ^ d[3] ^ d[4] ^ d[5] ^ d[7] ^ d[8] ^ d[12] ^ d[13] ^ d[14]
               ^ d[15] ^ d[16] ^ d[19] ^ d[20] ^ d[22];
        p[2] = d30s ^ d[2] ^ d[4] ^ d[5] ^ d[6] ^ d[8] ^ d[9] ^ d[13] ^ d[14] ^ d[15]
               ^ d[16] ^ d[17] ^ d[20] ^ d[21] ^ d[23];
        p[1] = d30s ^ d[1] ^ d[3] ^ d[5] ^ d[6] ^ d[7] ^ d[9] ^ d[10] ^ d[14] ^ d[15]
               ^ d[16] ^ d[17] ^ d[18] ^ d[21] ^ d[22] ^ d[24];
        p[0] = d29s ^ d[3] ^ d[5] ^ d[6] ^ d[8] ^ d[9] ^ d[10] ^ d[11] ^ d[13] ^ d[15]
               ^ d[19] ^ d[22] ^ d[23] ^ d[24];
        return p;
    endfunction

    // Sign-extends the low nbits of v to the 33-bit value width.
    function automatic logic [32:0] sext(logic [31:0] v, int nbits);
        logic [32:0] keep;
        keep = (33'd1 << nbits) - 33'd1;
        return v[nbits-1] ? ((33'(v) & keep) | ~keep) : (33'(v) & keep);
    endfunction

    function automatic void stage(field_code_t code, logic [32:0] value);
        stage_code[stage_count] = code;
        stage_val[stage_count]  = value;
        stage_count++;
    endfunction

    // Works out the fields one accepted word produces and queues them as expected results.
    function automatic void decode_nav_word(logic [31:0] raw, logic first_word);
        logic [31:0]   w;
        logic          good;
        field_result_t r;
        w = raw;
        stage_count = 0;
        // D30* of the previous word set means the data bits arrive inverted.
        if (w[30]) begin
            w[29:6] = ~w[29:6];
        end
        good = (parity_bits(w[31], w[30], w[29:6]) == w[5:0]);

        // Word position: a start flag restarts the count, otherwise it saturates at 11,
        // and it stays at zero until the first start after reset.
        if (first_word) begin
            pos_count = 4'd1;
            sf_id     = 3'd0;
        end else if (pos_count >= 4'd1 && pos_count < 4'd11) begin
            pos_count++;
        end

        if (pos_count == 4'd2) begin
            // Handover word: subframe id and the truncated time of week.
            sf_id = w[10:8];
            stage(FC_SUBFRAME_ID, 33'(sf_id));
            stage(FC_TOW, 33'(w[29:13]) * 33'd6);
        end else if (pos_count >= 4'd3 && pos_count <= 4'd10) begin
            case (sf_id)
                3'd1: begin
                    case (pos_count)
                        4'd3: begin
                            stage(FC_WEEK, 33'(w[29:20]) + 33'(week_ofs));
                            stage(FC_URA, 33'(w[17:14]));
                            stage(FC_HEALTH, 33'(w[13:8]));
                            iodc_top = w[7:6];
                        end
                        4'd7: stage(FC_TGD, sext(w[13:6], 8));
                        4'd8: begin
                            stage(FC_IODC, 33'({iodc_top, w[29:22]}));
                            stage(FC_TOC, 33'({w[21:6], 4'b0000}));
                        end
                        4'd9: begin
                            stage(FC_AF2, sext(w[29:22], 8));
                            stage(FC_AF1, sext(w[21:6], 16));
                        end
                        4'd10: begin
                            stage(FC_AF0, sext(w[29:8], 22));
                            done_mask[0] = 1'b1;
                        end
                        default: ;
                    endcase
                end
                3'd2: begin
                    // The 32-bit fields take their top byte from the word before.
                    case (pos_count)
                        4'd3: begin
                            stage(FC_IODE2, 33'(w[29:22]));
                            stage(FC_CRS, sext(w[21:6], 16));
                        end
                        4'd4: begin
                            stage(FC_DELTA_N, sext(w[29:14], 16));
                            held_byte = w[13:6];
                        end
                        4'd5: stage(FC_M0, sext({held_byte, w[29:6]}, 32));
                        4'd6: begin
                            stage(FC_CUC, sext(w[29:14], 16));
                            held_byte = w[13:6];
                        end
                        4'd7: stage(FC_ECC, 33'({held_byte, w[29:6]}));
                        4'd8: begin
                            stage(FC_CUS, sext(w[29:14], 16));
                            held_byte = w[13:6];
                        end
                        4'd9: stage(FC_SQRT_A, 33'({held_byte, w[29:6]}));
                        4'd10: begin
                            stage(FC_TOE, 33'({w[29:14], 4'b0000}));
                            done_mask[1] = 1'b1;
                        end
                        default: ;
                    endcase
                end
                3'd3: begin
                    case (pos_count)
                        4'd3: begin
                            stage(FC_CIC, sext(w[29:14], 16));
                            held_byte = w[13:6];
                        end
                        4'd4: stage(FC_OMEGA0, sext({held_byte, w[29:6]}, 32));
                        4'd5: begin
                            stage(FC_CIS, sext(w[29:14], 16));
                            held_byte = w[13:6];
                        end
                        4'd6: stage(FC_I0, sext({held_byte, w[29:6]}, 32));
                        4'd7: begin
                            stage(FC_CRC, sext(w[29:14], 16));
                            held_byte = w[13:6];
                        end
                        4'd8: stage(FC_OMEGA, sext({held_byte, w[29:6]}, 32));
                        4'd9: stage(FC_OMEGA_DOT, sext(w[29:6], 24));
                        4'd10: begin
                            stage(FC_IODE3, 33'(w[29:22]));
                            stage(FC_IDOT, sext(w[21:8], 14));
                            done_mask[2] = 1'b1;
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end

        // A word without a field still yields one result.
        if (stage_count == 0) begin
            stage(FC_NONE, '0);
        end

        // Subframe, position and ready flags are those after this word on every result.
        for (int k = 0; k < stage_count; k++) begin
            r.code      = stage_code[k];
            r.value     = stage_val[k];
            r.subframe  = sf_id;
            r.position  = pos_count;
            r.parity_ok = good;
            r.ready     = done_mask;
            r.last      = (k == stage_count - 1);
            expected_fields.push_back(r);
        end
    endfunction

    function automatic void compare_field(string name, logic [32:0] want, logic [32:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            failures++;
        end
    endfunction

    // Compares one result transaction with the oldest outstanding expectation.
    function automatic void check_result(logic [OUT_TDATA_W-1:0] data, logic tlast);
        gln_beat_t     beat;
        field_result_t want;
        beat = data;
        if (expected_fields.size() == 0) begin
            $error("result transaction with field code %0d arrived with none expected",
                   beat.field_code);
            failures++;
        end else begin
            want = expected_fields.pop_front();
            compare_field("field_code", 33'(want.code), 33'(beat.field_code));
            compare_field("field_value", want.value, beat.field_value);
            compare_field("subframe_number", 33'(want.subframe), 33'(beat.subframe_number));
            compare_field("word_position", 33'(want.position), 33'(beat.word_position));
            compare_field("parity_ok", 33'(want.parity_ok), 33'(beat.parity_ok));
            compare_field("ready_mask", 33'(want.ready), 33'(beat.ready_mask));
            compare_field("last", 33'(want.last), 33'(tlast));
        end
    endfunction

    // Encodes 24 data bits into a navigation word chained to the previous one. The data go
    // out inverted when D30* is set; a broken word gets one flipped bit in d1..D30.
    function automatic void queue_word(logic [23:0] data, logic first_word, logic corrupt);
        logic [31:0] w;
        int          flip;
        w = {gen_d29, gen_d30, gen_d30 ? ~data : data, parity_bits(gen_d29, gen_d30, data)};
        if (corrupt) begin
            flip = $urandom_range(0, 29);
            w[flip] = ~w[flip];
        end
        gen_d29 = w[1];
        gen_d30 = w[0];
        word_queue.push_back('{w, first_word});
    endfunction

    // A subframe of random content: telemetry word, handover word carrying id, and so on.
    function automatic void queue_subframe(logic [2:0] id, int nwords);
        logic [23:0] data;
        int          pick;
        for (int k = 1; k <= nwords; k++) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                data = '0;
            end else if (pick == 1) begin
                data = '1;
            end else begin
                data = 24'($urandom);
            end
            if (k == 2) begin
                data[4:2] = id;
            end
            queue_word(data, k == 1, $urandom_range(0, 99) < BAD_PARITY_PCT);
        end
    endfunction

    // Mostly complete subframes 1 to 3, then cut-off subframes, other ids, overlong
    // subframes and raw noise words with a stray start flag now and then.
    function automatic void queue_random_words(int target);
        int          made;
        int          pick;
        int          nwords;
        logic [2:0]  id;
        logic [31:0] noise;
        made = 0;
        while (made < target) begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 9) == 0) begin
                id = 3'($urandom_range(0, 7));
            end else begin
                id = 3'($urandom_range(1, 3));
            end
            if (pick < 70) begin
                nwords = ($urandom_range(0, 4) == 0) ? $urandom_range(11, 13) : 10;
                queue_subframe(id, nwords);
                made += nwords;
            end else if (pick < 85) begin
                nwords = $urandom_range(1, 9);
                queue_subframe(id, nwords);
                made += nwords;
            end else begin
                noise = $urandom;
                word_queue.push_back('{noise, $urandom_range(0, 7) == 0});
                gen_d29 = noise[1];
                gen_d30 = noise[0];
                made++;
            end
        end
    endfunction

    // Sender: offers the next pending word whenever the channel is free, idling at random.
    // The predictor runs on the edge where a word is accepted.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                decode_nav_word(s_tdata, s_tuser[0]);
                accepted_words++;
            end
            if (!s_tvalid || s_tready) begin
                if (word_queue.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                    next_word = word_queue.pop_front();
                    s_tvalid  <= 1'b1;
                    s_tdata   <= next_word.word;
                    s_tuser   <= next_word.first_word;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks every accepted result transaction and stalls at random, or for the
    // whole of a long hold-off.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                check_result(m_tdata, m_tlast);
            end
            m_tready <= !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Long receiver hold-off in the first random phase. The sender keeps offering words, so
    // the decoder's internal queue fills up and s_tready has to drop.
    initial begin
        do @(negedge aclk); while (accepted_words < 60);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(negedge aclk);
        rx_hold = 1'b0;
    end

    // APB write of week_offset: a setup cycle, then an access cycle held until pready.
    task automatic write_week_offset(logic [11:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_WEEK_OFFSET;
        pwdata  <= 32'(value);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        week_ofs = value;
    endtask

    // Waits until every word is accepted and every result has come, then lets the decoder
    // settle so that it is surely idle.
    task automatic wait_for_drain();
        int waited;
        waited = 0;
        do begin
            @(negedge aclk);
            waited++;
        end while ((word_queue.size() != 0 || s_tvalid || expected_fields.size() != 0)
                   && waited < DRAIN_LIMIT);
        if (expected_fields.size() != 0) begin
            $error("%0d expected results never arrived", expected_fields.size());
            failures++;
            expected_fields.delete();
        end
        repeat (4) @(negedge aclk);
    endtask

    // Stimulus: a directed part at the reset value of week_offset, then three random phases,
    // each under its own week offset and idling profile.
    initial begin
        logic [23:0] data;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // A word before any subframe start is not decoded and reports position zero.
        word_queue.push_back('{32'hFFFF_FFFF, 1'b0});
        // Subframe 1 with all data bits set past the telemetry word: largest week, negative
        // clock terms. Word 7 carries a parity error, which is only reported.
        for (int k = 1; k <= 10; k++) begin
            data = (k == 1) ? 24'h8B0000 : 24'hFFFFFF;
            if (k == 2) begin
                data[4:2] = 3'd1;
            end
            queue_word(data, k == 1, k == 7);
        end
        // Subframe 2 with zero data, except that the words holding a top byte carry the
        // sign bits alone, so M0 is most negative and ECC and SQRT_A have only the top bit set.
        for (int k = 1; k <= 10; k++) begin
            data = (k == 4 || k == 6 || k == 8) ? 24'h800080 : 24'h000000;
            if (k == 2) begin
                data[4:2] = 3'd2;
            end
            queue_word(data, k == 1, 1'b0);
        end
        // Subframe 3 with alternating all-ones and all-zeros words, and one word past ten.
        for (int k = 1; k <= 11; k++) begin
            data = (k % 2 == 1) ? 24'hFFFFFF : 24'h000000;
            if (k == 2) begin
                data[4:2] = 3'd3;
            end
            queue_word(data, k == 1, 1'b0);
        end
        // An unknown subframe id: only the handover word yields fields.
        queue_word(24'h000000, 1'b1, 1'b0);
        queue_word(24'h000014, 1'b0, 1'b0);
        queue_word(24'h5A5A5A, 1'b0, 1'b0);
        wait_for_drain();

        // Largest week offset; sender idles rarely, receiver often.
        write_week_offset(12'd4095);
        @(negedge aclk);
        queue_random_words(70);
        wait_for_drain();

        // Zero week offset; the idling profile is swapped.
        write_week_offset(12'd0);
        @(negedge aclk);
        tx_idle_pct = 62;
        rx_idle_pct = 14;
        queue_random_words(65);
        wait_for_drain();

        // Some week offset in between, with neither side idling.
        write_week_offset(12'($urandom_range(1, 4094)));
        @(negedge aclk);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        queue_random_words(65);
        wait_for_drain();

        // Allow for the output latency so that a stray extra result would still be caught.
        repeat (10) @(posedge aclk);
        if (failures == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Watchdog far beyond the slowest legal run.
    initial begin
        #5000000;
        $display("FAIL");
        $finish;
    end

endmodule
